>>> hw/rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// shared types, constants and round functions of the tea buffer cipher
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int ROUNDS_DEF    = 32;
  localparam int KEY_WORDS_DEF = 16;
  localparam int NUM_KEY_PAIRS = 8;
  localparam int KEY_IDX_W     = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int DATA_W        = 64;
  localparam int WORD_W        = 32;
  localparam int BYTE_W        = 8;

  localparam logic [31:0] DELTA32 = 32'h9e3779b9;
  localparam logic [7:0]  DELTA8  = 8'hb9;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_BLOCK = 2'd2
  } kind_e;

  // one unit travelling down the round chain
  typedef struct packed {
    logic                        dec;
    kind_e                       kind;
    logic [DATA_W-1:0]           data;
    logic [3:0][WORD_W-1:0]      key;
  } unit_t;

  function automatic logic [31:0] mix32(logic [31:0] v, logic [31:0] ka,
                                        logic [31:0] kb, logic [31:0] s);
    mix32 = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  function automatic logic [7:0] mix8(logic [7:0] v, logic [7:0] ka,
                                      logic [7:0] kb, logic [7:0] s);
    mix8 = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

>>> hw/rtl/tbc_cell.sv
// ----------------------------------------------------------------------------
// tbc_cell
// one registered tea round, byte-wide for pairs and word-wide for blocks; lone bytes pass unchanged
// ----------------------------------------------------------------------------
module tbc_cell #(
  parameter int ROUNDS    = tbc_pkg::ROUNDS_DEF,
  parameter int ROUND_IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tbc_pkg::unit_t unit_i,
  output logic           valid_o,
  output tbc_pkg::unit_t unit_o
);

  // running sum of this round, fixed per position in the chain
  localparam logic [31:0] SUM32_ENC =
    32'(64'(tbc_pkg::DELTA32) * 64'(ROUND_IDX + 1));
  localparam logic [31:0] SUM32_DEC =
    32'(64'(tbc_pkg::DELTA32) * 64'(ROUNDS - ROUND_IDX));
  localparam logic [7:0] SUM8_ENC =
    8'(32'(tbc_pkg::DELTA8) * 32'(ROUND_IDX + 1));
  localparam logic [7:0] SUM8_DEC =
    8'(32'(tbc_pkg::DELTA8) * 32'(ROUNDS - ROUND_IDX));

  logic           valid_q;
  tbc_pkg::unit_t unit_q;
  tbc_pkg::unit_t unit_d;
  logic [31:0]    s32, y32, z32, y32n, z32n;
  logic [7:0]     s8, y8, z8, y8n, z8n;

  always_comb begin
    unit_d = unit_i;
    s32    = unit_i.dec ? SUM32_DEC : SUM32_ENC;
    s8     = unit_i.dec ? SUM8_DEC : SUM8_ENC;
    y32    = unit_i.data[31:0];
    z32    = unit_i.data[63:32];
    y8     = unit_i.data[7:0];
    z8     = unit_i.data[15:8];
    y32n   = y32;
    z32n   = z32;
    y8n    = y8;
    z8n    = z8;
    case (unit_i.kind)
      tbc_pkg::KIND_PAIR: begin
        if (!unit_i.dec) begin
          y8n = y8 + tbc_pkg::mix8(z8, unit_i.key[0][7:0], unit_i.key[1][7:0], s8);
          z8n = z8 + tbc_pkg::mix8(y8n, unit_i.key[2][7:0], unit_i.key[3][7:0], s8);
        end else begin
          z8n = z8 - tbc_pkg::mix8(y8, unit_i.key[2][7:0], unit_i.key[3][7:0], s8);
          y8n = y8 - tbc_pkg::mix8(z8n, unit_i.key[0][7:0], unit_i.key[1][7:0], s8);
        end
        unit_d.data = {48'b0, z8n, y8n};
      end
      tbc_pkg::KIND_BLOCK: begin
        if (!unit_i.dec) begin
          y32n = y32 + tbc_pkg::mix32(z32, unit_i.key[0], unit_i.key[1], s32);
          z32n = z32 + tbc_pkg::mix32(y32n, unit_i.key[2], unit_i.key[3], s32);
        end else begin
          z32n = z32 - tbc_pkg::mix32(y32, unit_i.key[2], unit_i.key[3], s32);
          y32n = y32 - tbc_pkg::mix32(z32n, unit_i.key[0], unit_i.key[1], s32);
        end
        unit_d.data = {z32n, y32n};
      end
      default: begin
        unit_d = unit_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
    end
  end

  assign valid_o = valid_q;
  assign unit_o  = unit_q;

endmodule

>>> hw/rtl/tea_buffer_cipher.sv
// ----------------------------------------------------------------------------
// tea_buffer_cipher
// tea unit cipher: lone bytes, byte-wide tea pairs and 64-bit tea blocks
// ----------------------------------------------------------------------------
//
//  channel   signals                                    direction
//  -------   -----------------------------------------  ---------
//  in        in_valid_i/in_ready_o, func_i, start_req_i,  input
//            unit_kind_i, data_in_i
//  out       out_valid_o/out_ready_i, data_out_o          output
//  cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i             input
//
//  one transaction per cycle in and out while the output is not stalled;
//  each unit passes the entry register and then one registered round cell
//  per tea round, in the unrolled chain of round cells
//  a stalled output freezes the entry register and the whole chain together
//  reset clears key registers, pair and block counters and all valid flags
//
module tea_buffer_cipher #(
  parameter int ROUNDS    = tbc_pkg::ROUNDS_DEF,
  parameter int KEY_WORDS = tbc_pkg::KEY_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [tbc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tbc_pkg::DATA_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic                          start_req_i,
  input  logic [1:0]                    unit_kind_i,
  input  logic [tbc_pkg::DATA_W-1:0]    data_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tbc_pkg::DATA_W-1:0]    data_out_o
);

  // pair counter walks key words, block counter walks groups of four
  localparam int PC_W    = $clog2(KEY_WORDS);
  localparam int NGROUPS = KEY_WORDS / 4;
  localparam int BC_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

  logic [tbc_pkg::DATA_W-1:0] key_q [tbc_pkg::NUM_KEY_PAIRS];

  logic [PC_W-1:0] pc_q, pc_d, pc_eff;
  logic [BC_W-1:0] bc_q, bc_d, bc_eff;

  logic           adv;
  logic           in_fire;
  logic           entry_valid_q;
  tbc_pkg::unit_t entry_q;
  tbc_pkg::unit_t entry_d;

  logic [3:0]                     pair_widx;
  logic [31:0]                    pair_kw;
  logic [tbc_pkg::KEY_IDX_W-1:0]  blk_lo_idx, blk_hi_idx;

  tbc_pkg::unit_t  stage_unit [ROUNDS+1];
  logic [ROUNDS:0] stage_valid;

  // whole chain moves whenever the output register is free or being drained
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // key registers, writes past the last pair are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tbc_pkg::NUM_KEY_PAIRS; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i &&
                 (cfg_idx_i < tbc_pkg::CFG_IDX_W'(tbc_pkg::NUM_KEY_PAIRS))) begin
      key_q[cfg_idx_i[tbc_pkg::KEY_IDX_W-1:0]] <= cfg_wdata_i;
    end
  end

  // start of message restarts both counters before this unit uses them
  assign pc_eff = start_req_i ? '0 : pc_q;
  assign bc_eff = start_req_i ? '0 : bc_q;

  // key word for a pair, key group for a block
  assign pair_widx  = 4'(pc_eff);
  assign pair_kw    = pair_widx[0] ? key_q[pair_widx[3:1]][63:32]
                                   : key_q[pair_widx[3:1]][31:0];
  assign blk_lo_idx = tbc_pkg::KEY_IDX_W'({bc_eff, 1'b0});
  assign blk_hi_idx = tbc_pkg::KEY_IDX_W'({bc_eff, 1'b1});

  always_comb begin
    pc_d         = pc_eff;
    bc_d         = bc_eff;
    entry_d.dec  = func_i;
    entry_d.kind = tbc_pkg::kind_e'(unit_kind_i);
    entry_d.data = '0;
    entry_d.key  = '0;
    case (unit_kind_i)
      tbc_pkg::KIND_BYTE: begin
        // lone byte is finished here and just rides the chain
        entry_d.data = {56'b0, data_in_i[7:0] ^ key_q[0][7:0]};
      end
      tbc_pkg::KIND_PAIR: begin
        entry_d.data   = {48'b0, data_in_i[15:0]};
        entry_d.key[0] = {24'b0, pair_kw[7:0]};
        entry_d.key[1] = {24'b0, pair_kw[15:8]};
        entry_d.key[2] = {24'b0, pair_kw[23:16]};
        entry_d.key[3] = {24'b0, pair_kw[31:24]};
        pc_d = (pc_eff == PC_W'(KEY_WORDS - 1)) ? '0 : pc_eff + 1'b1;
      end
      tbc_pkg::KIND_BLOCK: begin
        entry_d.data   = data_in_i;
        entry_d.key[0] = key_q[blk_lo_idx][31:0];
        entry_d.key[1] = key_q[blk_lo_idx][63:32];
        entry_d.key[2] = key_q[blk_hi_idx][31:0];
        entry_d.key[3] = key_q[blk_hi_idx][63:32];
        bc_d = (bc_eff == BC_W'(NGROUPS - 1)) ? '0 : bc_eff + 1'b1;
      end
      default: begin
        // undefined kind gives zero and leaves the counters alone unless start_req_i restarts them
        entry_d.data = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= '0;
      bc_q          <= '0;
      entry_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pc_q <= pc_d;
        bc_q <= bc_d;
      end
      if (adv) begin
        entry_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      entry_q <= entry_d;
    end
  end

  // chain of round cells, last cell register is the output register
  assign stage_unit[0]  = entry_q;
  assign stage_valid[0] = entry_valid_q;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    tbc_cell #(
      .ROUNDS   (ROUNDS),
      .ROUND_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(stage_valid[g]),
      .unit_i (stage_unit[g]),
      .valid_o(stage_valid[g+1]),
      .unit_o (stage_unit[g+1])
    );
  end

  assign out_valid_o = stage_valid[ROUNDS];
  assign data_out_o  = stage_unit[ROUNDS].data;

  // counters stay inside their key ranges
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_W'(KEY_WORDS - 1))
    else $error("pair counter out of range");

  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BC_W'(NGROUPS - 1))
    else $error("block counter out of range");

  // first pair of a message takes key word 0, so the next one is 1
  a_start_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && start_req_i && (unit_kind_i == tbc_pkg::KIND_PAIR)
    |=> pc_q == PC_W'(1))
    else $error("pair counter not restarted by start");

  // lone byte without a start leaves both counters untouched
  a_byte_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !start_req_i && (unit_kind_i == tbc_pkg::KIND_BYTE)
    |=> $stable(pc_q) && $stable(bc_q))
    else $error("counters moved on lone byte");

  // pair results never carry bits above the pair
  a_pair_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stage_unit[ROUNDS].kind == tbc_pkg::KIND_PAIR)
    |-> data_out_o[63:16] == '0)
    else $error("pair result has upper bits set");

endmodule
